[rtl/hsm_pkg.sv]
package hsm_pkg;

	localparam int TIME_W   = 32;
	localparam int CNT_W    = 16;
	localparam int BUDGET_W = 16;
	localparam int HB_W     = 17;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd4;

	localparam logic [BUDGET_W-1:0] HOLD_RST  = 16'd1500;
	localparam logic [BUDGET_W-1:0] ALARM_RST = 16'd2500;
	localparam logic [BUDGET_W-1:0] FAULT_RST = 16'd6000;
	localparam logic [BUDGET_W-1:0] RESET_RST = 16'd2500;

	localparam logic signed [HB_W-1:0] HB_NONE = -17'sd1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		HS_INIT  = 2'd0,
		HS_OK    = 2'd1,
		HS_ALARM = 2'd2,
		HS_FAULT = 2'd3
	} health_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] hold_ms;
		logic [BUDGET_W-1:0] alarm_ms;
		logic [BUDGET_W-1:0] fault_ms;
		logic [BUDGET_W-1:0] reset_ms;
		logic                bypass;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]      prev_time;
		logic                   time_valid;
		logic signed [HB_W-1:0] prev_hb;
		logic                   change_seen;
		logic [TIME_W-1:0]      change_time;
		logic                   init_f;
		logic                   ok_f;
		logic                   fault_f;
		logic                   alarm_f;
		logic [BUDGET_W-1:0]    fault_left;
		logic [BUDGET_W-1:0]    alarm_left;
		logic [BUDGET_W-1:0]    reset_left;
		health_t                code;
		logic [CNT_W-1:0]       alarm_ev;
		logic [CNT_W-1:0]       fault_ev;
		logic [CNT_W-1:0]       alarm_polls;
		logic [CNT_W-1:0]       fault_polls;
	} mon_state_t;

	function automatic logic [BUDGET_W-1:0] drain(input logic [BUDGET_W-1:0] left,
			input logic [TIME_W-1:0] amount);
		if (amount >= TIME_W'(left))
			return '0;
		return left - amount[BUDGET_W-1:0];
	endfunction

	function automatic logic [BUDGET_W-1:0] refill(input logic [BUDGET_W-1:0] left,
			input logic [TIME_W-1:0] amount, input logic [BUDGET_W-1:0] top);
		logic [BUDGET_W-1:0] room;
		room = top - left;
		if (left >= top)
			return left;
		if (amount >= TIME_W'(room))
			return top;
		return left + amount[BUDGET_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

[rtl/hsm_step.sv]
module hsm_step import hsm_pkg::*; (
	input  cfg_t                   cfg,
	input  mon_state_t             st,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic signed [HB_W-1:0] heartbeat,
	output mon_state_t             nxt
);

	logic [TIME_W-1:0] dt;
	logic [TIME_W-1:0] stall;

	assign dt    = st.time_valid ? (now_ms - st.prev_time) : '0;
	assign stall = now_ms - st.change_time;

	always_comb begin
		nxt = st;
		nxt.prev_time  = now_ms;
		nxt.time_valid = 1'b1;
		if (!cfg.bypass) begin
			if (heartbeat == HB_NONE) begin
				nxt.init_f = 1'b1;
			end else begin
				if (heartbeat != st.prev_hb) begin
					nxt.prev_hb     = heartbeat;
					nxt.change_seen = 1'b1;
					nxt.change_time = now_ms;
				end else if (st.change_seen) begin
					if (stall > TIME_W'(cfg.hold_ms)) begin
						nxt.change_seen = 1'b0;
						nxt.alarm_left  = drain(st.alarm_left, stall);
						nxt.fault_left  = drain(st.fault_left, stall);
					end
				end

				if (nxt.change_seen) begin
					if (!st.ok_f) begin
						nxt.reset_left = drain(st.reset_left, dt);
						if (nxt.reset_left == '0) begin
							nxt.fault_f    = 1'b0;
							nxt.alarm_f    = 1'b0;
							nxt.ok_f       = 1'b1;
							nxt.code       = HS_OK;
							nxt.reset_left = cfg.reset_ms;
						end
					end
				end else begin
					nxt.fault_left = drain(nxt.fault_left, dt);
					nxt.alarm_left = drain(nxt.alarm_left, dt);
					if (nxt.fault_left == '0 && !st.fault_f) begin
						nxt.fault_f  = 1'b1;
						nxt.alarm_f  = 1'b1;
						nxt.ok_f     = 1'b0;
						nxt.code     = HS_FAULT;
						nxt.fault_ev = sat_inc(st.fault_ev);
					end else if (nxt.alarm_left == '0 && !st.alarm_f) begin
						nxt.alarm_f  = 1'b1;
						nxt.ok_f     = 1'b0;
						nxt.code     = HS_ALARM;
						nxt.alarm_ev = sat_inc(st.alarm_ev);
					end
				end

				if (nxt.fault_f)
					nxt.fault_polls = sat_inc(st.fault_polls);
				else if (nxt.change_seen)
					nxt.fault_left = refill(nxt.fault_left, dt, cfg.fault_ms);

				if (nxt.alarm_f)
					nxt.alarm_polls = sat_inc(st.alarm_polls);
				else if (nxt.change_seen)
					nxt.alarm_left = refill(nxt.alarm_left, dt, cfg.alarm_ms);
			end
		end
	end

endmodule

[rtl/heartbeat_stall_monitor_unit.sv]
// A poll transfer reaches the result through the input register, then state and
// result update from one pass of logic.
// Throughput: one poll per cycle while results are taken; a held result stalls input.
// Reset (arst_n low, async): budgets and registers return to their defaults,
// flags, counters and time history clear; no result is pending.
module heartbeat_stall_monitor_unit import hsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic signed [HB_W-1:0] heartbeat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             health_state,
	output logic                   alarm_active,
	output logic                   fault_active,
	output logic                   init_seen,
	output logic [CNT_W-1:0]       alarm_events,
	output logic [CNT_W-1:0]       fault_events,
	output logic [CNT_W-1:0]       alarm_polls,
	output logic [CNT_W-1:0]       fault_polls
);

	cfg_t                   cfg_q;
	mon_state_t             st_q;
	mon_state_t             st_nxt;
	logic                   valid_s1;
	logic [TIME_W-1:0]      now_s1;
	logic signed [HB_W-1:0] hb_s1;
	logic                   adv;

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms  <= HOLD_RST;
			cfg_q.alarm_ms <= ALARM_RST;
			cfg_q.fault_ms <= FAULT_RST;
			cfg_q.reset_ms <= RESET_RST;
			cfg_q.bypass   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLD:   cfg_q.hold_ms  <= cfg_data;
				REG_ALARM:  cfg_q.alarm_ms <= cfg_data;
				REG_FAULT:  cfg_q.fault_ms <= cfg_data;
				REG_RESET:  cfg_q.reset_ms <= cfg_data;
				REG_BYPASS: cfg_q.bypass   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_ms;
			hb_s1  <= heartbeat;
		end
	end

	hsm_step u_step (
		.cfg       (cfg_q),
		.st        (st_q),
		.now_ms    (now_s1),
		.heartbeat (hb_s1),
		.nxt       (st_nxt)
	);

	// state doubles as the result register: it only moves when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prev_time   <= '0;
			st_q.time_valid  <= 1'b0;
			st_q.prev_hb     <= HB_NONE;
			st_q.change_seen <= 1'b0;
			st_q.change_time <= '0;
			st_q.init_f      <= 1'b0;
			st_q.ok_f        <= 1'b0;
			st_q.fault_f     <= 1'b0;
			st_q.alarm_f     <= 1'b0;
			st_q.fault_left  <= FAULT_RST;
			st_q.alarm_left  <= ALARM_RST;
			st_q.reset_left  <= RESET_RST;
			st_q.code        <= HS_INIT;
			st_q.alarm_ev    <= '0;
			st_q.fault_ev    <= '0;
			st_q.alarm_polls <= '0;
			st_q.fault_polls <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	assign health_state = st_q.code;
	assign alarm_active = st_q.alarm_f;
	assign fault_active = st_q.fault_f;
	assign init_seen    = st_q.init_f;
	assign alarm_events = st_q.alarm_ev;
	assign fault_events = st_q.fault_ev;
	assign alarm_polls  = st_q.alarm_polls;
	assign fault_polls  = st_q.fault_polls;

	a_fault_implies_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fault_f |-> st_q.alarm_f)
		else $error("fault latched without alarm");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.code == HS_FAULT) == st_q.fault_f)
		else $error("health code disagrees with fault flag");

	a_alarm_code: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.code == HS_ALARM) == (st_q.alarm_f && !st_q.fault_f))
		else $error("health code disagrees with alarm flag");

	a_events_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.alarm_ev >= $past(st_q.alarm_ev)) && (st_q.fault_ev >= $past(st_q.fault_ev)))
		else $error("event counter decreased");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(st_q))
		else $error("state moved while result waits");

endmodule

[verif/heartbeat_stall_monitor_unit_check.sv]
`timescale 1ns / 100ps

module heartbeat_stall_monitor_unit_check import hsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic signed [HB_W-1:0] heartbeat,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [1:0]             health_state,
	input  logic                   alarm_active,
	input  logic                   fault_active,
	input  logic                   init_seen,
	input  logic [CNT_W-1:0]       alarm_events,
	input  logic [CNT_W-1:0]       fault_events,
	input  logic [CNT_W-1:0]       alarm_polls,
	input  logic [CNT_W-1:0]       fault_polls,
	output int                     fail_cnt,
	output int                     pending_cnt
);

	typedef struct packed {
		health_t          health;
		logic             alarm;
		logic             fault;
		logic             init;
		logic [CNT_W-1:0] alarm_ev;
		logic [CNT_W-1:0] fault_ev;
		logic [CNT_W-1:0] alarm_poll;
		logic [CNT_W-1:0] fault_poll;
	} health_report_t;

	health_report_t reports_due[$];
	int errs = 0;

	logic [BUDGET_W-1:0] hold_cfg, alarm_cfg, fault_cfg, reset_cfg;
	logic                bypass_cfg;

	logic [TIME_W-1:0]   last_t, beat_t;
	logic                have_t, beating;
	logic [HB_W-1:0]     last_hb;
	logic                init_f, ok_f, fault_f, alarm_f;
	logic [BUDGET_W-1:0] fault_rem, alarm_rem, settle_rem;
	health_t             health;
	logic [CNT_W-1:0]    n_alarm_ev, n_fault_ev, n_alarm_poll, n_fault_poll;

	function automatic logic [BUDGET_W-1:0] spend(input logic [BUDGET_W-1:0] left,
			input logic [TIME_W-1:0] amount);
		if (amount >= TIME_W'(left))
			return '0;
		return left - BUDGET_W'(amount);
	endfunction

	function automatic logic [BUDGET_W-1:0] topup(input logic [BUDGET_W-1:0] left,
			input logic [TIME_W-1:0] amount, input logic [BUDGET_W-1:0] top);
		if (left >= top)
			return left;
		if (amount >= TIME_W'(top - left))
			return top;
		return left + BUDGET_W'(amount);
	endfunction

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic int field_ok(input string name, input int want, input int got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	task automatic clear_monitor();
		hold_cfg = HOLD_RST;
		alarm_cfg = ALARM_RST;
		fault_cfg = FAULT_RST;
		reset_cfg = RESET_RST;
		bypass_cfg = 1'b0;
		last_t = '0;
		have_t = 1'b0;
		last_hb = HB_NONE;
		beating = 1'b0;
		beat_t = '0;
		init_f = 1'b0;
		ok_f = 1'b0;
		fault_f = 1'b0;
		alarm_f = 1'b0;
		fault_rem = FAULT_RST;
		alarm_rem = ALARM_RST;
		settle_rem = RESET_RST;
		health = HS_INIT;
		n_alarm_ev = '0;
		n_fault_ev = '0;
		n_alarm_poll = '0;
		n_fault_poll = '0;
	endtask

	task automatic advance_monitor(input logic [TIME_W-1:0] t, input logic [HB_W-1:0] hb,
			output health_report_t r);
		logic [TIME_W-1:0] dt;
		logic [TIME_W-1:0] stall;
		dt = have_t ? t - last_t : '0;
		last_t = t;
		have_t = 1'b1;
		if (!bypass_cfg) begin
			if (hb == HB_NONE) begin
				init_f = 1'b1;
			end else begin
				if (hb != last_hb) begin
					last_hb = hb;
					beating = 1'b1;
					beat_t = t;
				end else if (beating) begin
					stall = t - beat_t;
					if (stall > TIME_W'(hold_cfg)) begin
						beating = 1'b0;
						alarm_rem = spend(alarm_rem, stall);
						fault_rem = spend(fault_rem, stall);
					end
				end
				if (beating) begin
					if (!ok_f) begin
						settle_rem = spend(settle_rem, dt);
						if (settle_rem == '0) begin
							fault_f = 1'b0;
							alarm_f = 1'b0;
							ok_f = 1'b1;
							health = HS_OK;
							settle_rem = reset_cfg;
						end
					end
				end else begin
					fault_rem = spend(fault_rem, dt);
					alarm_rem = spend(alarm_rem, dt);
					if (fault_rem == '0 && !fault_f) begin
						fault_f = 1'b1;
						alarm_f = 1'b1;
						ok_f = 1'b0;
						health = HS_FAULT;
						n_fault_ev = count_up(n_fault_ev);
					end else if (alarm_rem == '0 && !alarm_f) begin
						alarm_f = 1'b1;
						ok_f = 1'b0;
						health = HS_ALARM;
						n_alarm_ev = count_up(n_alarm_ev);
					end
				end
				if (fault_f)
					n_fault_poll = count_up(n_fault_poll);
				else if (beating)
					fault_rem = topup(fault_rem, dt, fault_cfg);
				if (alarm_f)
					n_alarm_poll = count_up(n_alarm_poll);
				else if (beating)
					alarm_rem = topup(alarm_rem, dt, alarm_cfg);
			end
		end
		r.health = health;
		r.alarm = alarm_f;
		r.fault = fault_f;
		r.init = init_f;
		r.alarm_ev = n_alarm_ev;
		r.fault_ev = n_fault_ev;
		r.alarm_poll = n_alarm_poll;
		r.fault_poll = n_fault_poll;
	endtask

	always @(posedge clk or negedge arst_n) begin
		health_report_t r;
		health_report_t want;
		if (!arst_n) begin
			clear_monitor();
			reports_due.delete();
			pending_cnt <= 0;
			fail_cnt <= errs;
		end else begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$error("result transfer with no poll outstanding");
					errs++;
				end else begin
					want = reports_due.pop_front();
					errs += field_ok("health_state", int'(want.health), int'(health_state));
					errs += field_ok("alarm_active", int'(want.alarm), int'(alarm_active));
					errs += field_ok("fault_active", int'(want.fault), int'(fault_active));
					errs += field_ok("init_seen", int'(want.init), int'(init_seen));
					errs += field_ok("alarm_events", int'(want.alarm_ev), int'(alarm_events));
					errs += field_ok("fault_events", int'(want.fault_ev), int'(fault_events));
					errs += field_ok("alarm_polls", int'(want.alarm_poll), int'(alarm_polls));
					errs += field_ok("fault_polls", int'(want.fault_poll), int'(fault_polls));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD: hold_cfg = cfg_data;
					REG_ALARM: alarm_cfg = cfg_data;
					REG_FAULT: fault_cfg = cfg_data;
					REG_RESET: reset_cfg = cfg_data;
					REG_BYPASS: bypass_cfg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				advance_monitor(now_ms, heartbeat, r);
				reports_due.push_back(r);
			end
			pending_cnt <= reports_due.size();
			fail_cnt <= errs;
		end
	end

endmodule

[verif/heartbeat_stall_monitor_unit_test.sv]
`timescale 1ns / 100ps

module heartbeat_stall_monitor_unit_test;
	import hsm_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [TIME_W-1:0]      now_ms = '0;
	logic signed [HB_W-1:0] heartbeat = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             health_state;
	logic                   alarm_active;
	logic                   fault_active;
	logic                   init_seen;
	logic [CNT_W-1:0]       alarm_events;
	logic [CNT_W-1:0]       fault_events;
	logic [CNT_W-1:0]       alarm_polls;
	logic [CNT_W-1:0]       fault_polls;
	int                     fail_cnt;
	int                     pending_cnt;

	// no idling on either side while set
	bit                     calm = 1'b0;
	logic [TIME_W-1:0]      clock_ms = '0;
	logic [HB_W-1:0]        beat = HB_NONE;
	int unsigned            span = 1;

	heartbeat_stall_monitor_unit u_dut (.*);

	heartbeat_stall_monitor_unit_check u_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 11);

	initial begin
		#5000000;
		$display("** heartbeat_stall_monitor_unit: FAILED **");
		$finish;
	end

	task automatic send_poll(input logic [TIME_W-1:0] t, input logic [HB_W-1:0] hb);
		if (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 11)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		heartbeat <= hb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		clock_ms = t;
		if (hb != HB_NONE)
			beat = hb;
	endtask

	task automatic beat_poll(input int unsigned dt, input bit change);
		logic [HB_W-1:0] v;
		v = beat;
		if (change) begin
			do
				v = HB_W'($urandom);
			while (v == beat || v == HB_NONE);
		end
		send_poll(clock_ms + dt, v);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [BUDGET_W-1:0] hold, input logic [BUDGET_W-1:0] alarm,
			input logic [BUDGET_W-1:0] fault, input logic [BUDGET_W-1:0] settle, input bit byp);
		int unsigned m;
		wait_idle();
		write_reg(REG_HOLD, hold);
		write_reg(REG_ALARM, alarm);
		write_reg(REG_FAULT, fault);
		write_reg(REG_RESET, settle);
		write_reg(REG_BYPASS, CFG_W'(byp));
		cfg_we <= 1'b0;
		m = 32'(hold);
		if (32'(alarm) > m) m = 32'(alarm);
		if (32'(fault) > m) m = 32'(fault);
		if (32'(settle) > m) m = 32'(settle);
		span = m / 4 + 2;
	endtask

	// runs of steady beats, stalls, mixed runs, not-started polls and noise
	task automatic random_polls(input int count);
		int done;
		int n;
		int kind;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(9);
			n = (kind >= 8) ? $urandom_range(1, 3) : $urandom_range(1, 18);
			repeat (n) begin
				case (kind) inside
					[0:3]: beat_poll($urandom_range(span / 2), 1'b1);
					[4:6]: beat_poll($urandom_range(span), 1'b0);
					7: beat_poll($urandom_range(span), 1'($urandom_range(1)));
					8: send_poll(clock_ms + $urandom_range(span), HB_NONE);
					default: send_poll($urandom, HB_W'($urandom));
				endcase
			end
			done += n;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first poll, wrap, stall into alarm then fault, odd beats
		send_poll(32'hFFFF_FC00, HB_NONE);
		send_poll(32'hFFFF_FE00, 17'h00000);
		send_poll(32'h0000_0100, 17'h00001);
		send_poll(32'h0000_0900, 17'h0FFFF);
		send_poll(32'h0000_0A00, 17'h0FFFF);
		send_poll(32'h0000_1200, 17'h0FFFF);
		send_poll(32'h0000_2000, 17'h0FFFF);
		send_poll(32'h0000_2000, 17'h0FFFF);
		send_poll(32'h0000_2080, HB_NONE);
		send_poll(32'h0000_2100, 17'h10000);
		send_poll(32'h0000_2200, 17'h1FFFE);
		send_poll(32'hFFFF_FFFF, 17'h1FFFE);
		send_poll(32'h0000_0000, 17'h0AAAA);
		send_poll(32'h0000_0001, 17'h15555);
		send_poll(32'h0000_0001, 17'h15555);
		send_poll(32'h0000_0002, 17'h0AAAA);

		set_config(HOLD_RST, ALARM_RST, FAULT_RST, RESET_RST, 1'b0);
		random_polls(300);
		set_config('0, '0, '0, '0, 1'b0);
		random_polls(250);
		set_config('1, '1, '1, '1, 1'b0);
		random_polls(300);
		// budgets may now sit above the lowered registers
		calm = 1'b1;
		set_config(16'd200, 16'd100, 16'd300, 16'd150, 1'b0);
		random_polls(250);
		calm = 1'b0;
		repeat (2) begin
			set_config(16'($urandom_range(3000)), 16'($urandom_range(3000)),
				16'($urandom_range(3000)), 16'($urandom_range(3000)), 1'b0);
			random_polls(250);
		end
		set_config(HOLD_RST, ALARM_RST, FAULT_RST, RESET_RST, 1'b1);
		random_polls(120);

		wait_idle();
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("** heartbeat_stall_monitor_unit: PASSED **");
		else
			$display("** heartbeat_stall_monitor_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/hsm_pkg.sv
rtl/hsm_step.sv
rtl/heartbeat_stall_monitor_unit.sv
verif/heartbeat_stall_monitor_unit_check.sv
verif/heartbeat_stall_monitor_unit_test.sv
